// ===== design/verlet_2d_body_integrator_macros.svh =====
// assertion macros shared by the verlet body integrator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef VERLET_2D_BODY_INTEGRATOR_MACROS_SVH
`define VERLET_2D_BODY_INTEGRATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define V2BI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v2bi check failed");

// next-cycle implication, disabled while reset is asserted
`define V2BI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v2bi check failed");

`endif

// ===== design/v2bi_pkg.sv =====
// types, operation codes and helpers for the verlet body integrator
// no dependencies
`default_nettype none

package v2bi_pkg;

    localparam logic [1:0] OP_SET_POS = 2'd0;
    localparam logic [1:0] OP_SET_ACC = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [4:0]  body_slot;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic        [15:0] time_step;
    } t_cmd;

    typedef struct packed {
        logic        [4:0]  slot_index;
        logic               is_active;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic               end_of_run;
    } t_result;

    // one row of the position memory
    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
    } t_pos_entry;

    // one row of the acceleration memory
    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } t_acc_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // clamp a 35-bit two's complement sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic [34:0] s);
        logic signed [31:0] r;
        if ((s[34:31] == 4'b0000) || (s[34:31] == 4'b1111)) begin
            r = s[31:0];
        end else if (s[34]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/v2bi_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module v2bi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/verlet_2d_body_integrator.sv =====
// top level of the 2d position-verlet body integrator
// depends on v2bi_pkg, v2bi_ram and verlet_2d_body_integrator_macros.svh
//
//  channel   ports                       handshake
//  --------  --------------------------  ---------------------------------------
//  command   start, i_cmd, busy          item taken when start && !busy
//  result    o_strobe, o_result          one cycle per item, cannot be held off
//
//  busy never rises for set position or set acceleration
//  a step keeps busy high until its last slot has left stage 2, so no new item is taken
//  meanwhile; the single read port of the position memory has the step read the slots in turn
//  results come out one per cycle in slot order; the first follows accept via the sequencer, stages 1 and 2
//  reset (synchronous, active low) clears valid bits and the sequencer, not the memories
//  the result side has no stall; nothing upstream of it waits on it
`default_nettype none

`include "verlet_2d_body_integrator_macros.svh"

module verlet_2d_body_integrator #(
    parameter int NUM_BODIES = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire v2bi_pkg::t_cmd   i_cmd,
    output logic                  busy,
    output logic                  o_strobe,
    output v2bi_pkg::t_result     o_result
);

    localparam int AW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BODIES - 1);

    // sequencer
    v2bi_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_rd_idx;
    logic             w_issue;

    // per-slot flags held in flops
    logic [NUM_BODIES-1:0] r_body_vld;
    logic [NUM_BODIES-1:0] r_acc_vld;   // cleared means acceleration reads as zero

    // time step squared, q0.32
    logic [31:0] r_dt2;

    // stage 1: memory data out
    logic          r_s1_vld;
    logic          r_s1_last;
    logic [AW-1:0] r_s1_idx;

    // stage 2: products and velocities
    logic                r_s2_vld;
    logic                r_s2_last;
    logic                r_s2_act;
    logic [AW-1:0]       r_s2_idx;
    logic [63:0]         r_s2_px;
    logic [63:0]         r_s2_py;
    logic signed [31:0]  r_s2_cx;
    logic signed [31:0]  r_s2_cy;
    logic [32:0]         r_s2_vx;
    logic [32:0]         r_s2_vy;

    // command decode
    logic          w_accept;
    logic          w_idx_ok;
    logic          w_set_pos;
    logic          w_set_acc;
    logic          w_step;
    logic [AW-1:0] w_cmd_idx;

    assign w_accept  = start && !busy;
    assign w_idx_ok  = (32'(i_cmd.body_slot) < 32'(NUM_BODIES));
    assign w_cmd_idx = AW'(i_cmd.body_slot);
    assign w_set_pos = w_accept && (i_cmd.operation == v2bi_pkg::OP_SET_POS) && w_idx_ok;
    assign w_set_acc = w_accept && (i_cmd.operation == v2bi_pkg::OP_SET_ACC) && w_idx_ok;
    assign w_step    = w_accept && (i_cmd.operation == v2bi_pkg::OP_STEP);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            v2bi_pkg::ST_IDLE: begin
                if (w_step) begin
                    n_state = v2bi_pkg::ST_RUN;
                end
            end
            v2bi_pkg::ST_RUN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = v2bi_pkg::ST_DRAIN;
                end
            end
            v2bi_pkg::ST_DRAIN: begin
                // last slot leaves stage 2 at this edge
                if (r_s2_vld && r_s2_last) begin
                    n_state = v2bi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = v2bi_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy    = (r_state != v2bi_pkg::ST_IDLE);
        w_issue = (r_state == v2bi_pkg::ST_RUN);
    end

    // position memory: cur and prev for both axes
    v2bi_pkg::t_pos_entry w_pos_rd;
    v2bi_pkg::t_pos_entry w_pos_wr;
    logic                 w_pos_we;
    logic [AW-1:0]        w_pos_waddr;

    // acceleration memory
    v2bi_pkg::t_acc_entry w_acc_rd;
    v2bi_pkg::t_acc_entry w_acc_wr;

    // stage 2 results
    logic [32:0]        w_term_x;
    logic [32:0]        w_term_y;
    logic [34:0]        w_sum_x;
    logic [34:0]        w_sum_y;
    logic signed [31:0] w_new_x;
    logic signed [31:0] w_new_y;
    logic               w_wb;

    assign w_wb = r_s2_vld && r_s2_act;

    // set position and writeback never meet: sets are taken only while idle
    always_comb begin
        w_pos_we    = w_set_pos || w_wb;
        w_pos_waddr = w_wb ? r_s2_idx : w_cmd_idx;
        if (w_wb) begin
            w_pos_wr.cur_x  = w_new_x;
            w_pos_wr.cur_y  = w_new_y;
            w_pos_wr.prev_x = r_s2_cx;
            w_pos_wr.prev_y = r_s2_cy;
        end else begin
            w_pos_wr.cur_x  = i_cmd.value_x;
            w_pos_wr.cur_y  = i_cmd.value_y;
            w_pos_wr.prev_x = i_cmd.value_x;
            w_pos_wr.prev_y = i_cmd.value_y;
        end
        w_acc_wr.acc_x = i_cmd.value_x;
        w_acc_wr.acc_y = i_cmd.value_y;
    end

    v2bi_ram #(
        .WIDTH ($bits(v2bi_pkg::t_pos_entry)),
        .DEPTH (NUM_BODIES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_waddr),
        .i_wdata (w_pos_wr),
        .i_raddr (r_rd_idx),
        .o_rdata (w_pos_rd)
    );

    v2bi_ram #(
        .WIDTH ($bits(v2bi_pkg::t_acc_entry)),
        .DEPTH (NUM_BODIES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_set_acc),
        .i_waddr (w_cmd_idx),
        .i_wdata (w_acc_wr),
        .i_raddr (r_rd_idx),
        .o_rdata (w_acc_rd)
    );

    // stage 1: accel * dt^2 as q16.48, velocity as cur - prev
    logic signed [31:0] w_ax;
    logic signed [31:0] w_ay;
    logic signed [63:0] w_prod_x;
    logic signed [63:0] w_prod_y;

    // magnitude stays below 2^63, so 64 bits hold the product exactly
    assign w_ax     = r_acc_vld[r_s1_idx] ? w_acc_rd.acc_x : 32'sd0;
    assign w_ay     = r_acc_vld[r_s1_idx] ? w_acc_rd.acc_y : 32'sd0;
    assign w_prod_x = w_ax * $signed({1'b0, r_dt2});
    assign w_prod_y = w_ay * $signed({1'b0, r_dt2});

    // stage 2: round the product to q16.16 (halves up), sum, clamp
    assign w_term_x = {r_s2_px[63], r_s2_px[63:32]} + {32'd0, r_s2_px[31]};
    assign w_term_y = {r_s2_py[63], r_s2_py[63:32]} + {32'd0, r_s2_py[31]};
    assign w_sum_x  = {{3{r_s2_cx[31]}}, r_s2_cx} + {{2{r_s2_vx[32]}}, r_s2_vx}
                    + {{2{w_term_x[32]}}, w_term_x};
    assign w_sum_y  = {{3{r_s2_cy[31]}}, r_s2_cy} + {{2{r_s2_vy[32]}}, r_s2_vy}
                    + {{2{w_term_y[32]}}, w_term_y};
    assign w_new_x  = v2bi_pkg::sat32(w_sum_x);
    assign w_new_y  = v2bi_pkg::sat32(w_sum_y);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= v2bi_pkg::ST_IDLE;
            r_rd_idx   <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            o_strobe   <= 1'b0;
            r_body_vld <= '0;
            r_acc_vld  <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            o_strobe <= r_s2_vld;
            if (w_step) begin
                r_rd_idx <= '0;
            end else if (w_issue && (r_rd_idx != LAST_IDX)) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
            if (w_set_pos) begin
                r_body_vld[w_cmd_idx] <= 1'b1;
            end
            // a step consumes the acceleration of every active body
            if (w_set_acc) begin
                r_acc_vld[w_cmd_idx] <= 1'b1;
            end else if (w_wb) begin
                r_acc_vld[r_s2_idx] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_dt2 <= 32'(i_cmd.time_step) * 32'(i_cmd.time_step);
        end
        r_s1_idx  <= r_rd_idx;
        r_s1_last <= (r_rd_idx == LAST_IDX);
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        r_s2_act  <= r_body_vld[r_s1_idx];
        r_s2_px   <= w_prod_x;
        r_s2_py   <= w_prod_y;
        r_s2_cx   <= w_pos_rd.cur_x;
        r_s2_cy   <= w_pos_rd.cur_y;
        r_s2_vx   <= {w_pos_rd.cur_x[31], w_pos_rd.cur_x} - {w_pos_rd.prev_x[31], w_pos_rd.prev_x};
        r_s2_vy   <= {w_pos_rd.cur_y[31], w_pos_rd.cur_y} - {w_pos_rd.prev_y[31], w_pos_rd.prev_y};
        o_result.slot_index <= 5'(r_s2_idx);
        o_result.is_active  <= r_s2_act;
        o_result.new_x      <= r_s2_act ? w_new_x : 32'sd0;
        o_result.new_y      <= r_s2_act ? w_new_y : 32'sd0;
        o_result.end_of_run <= r_s2_last;
    end

    // checks
    `V2BI_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    `V2BI_ASSERT_IMP(a_last_frees_block, i_clk, i_rst_n, o_strobe && o_result.end_of_run, !busy)
    `V2BI_ASSERT_IMP(a_writeback_in_step, i_clk, i_rst_n, r_s2_vld, busy)
    `V2BI_ASSERT_NXT(a_step_starts_walk, i_clk, i_rst_n, w_step,
                     (r_state == v2bi_pkg::ST_RUN) && (r_rd_idx == '0) && !r_s1_vld)

endmodule

`default_nettype wire

// ===== test/tb_verlet_2d_body_integrator.sv =====
// self-checking bench for verlet_2d_body_integrator: directed table, then random commands
// depends on v2bi_pkg and the integrator rtl; step reports are predicted by a local body table
`timescale 1ns / 100ps

module tb_verlet_2d_body_integrator;
    import v2bi_pkg::*;

    localparam int NUM_BODIES   = 32;
    localparam logic [1:0] OP_NONE = 2'd3;  // unused code, must be a no-op
    localparam int RANDOM_ITEMS = 260;
    localparam int CALM_TAIL    = 40;       // last random items go out back to back
    localparam int DRAIN_CYCLES = 40;       // idle wait once every owed report is back
    localparam int DIRECTED_ROWS = 25;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    verlet_2d_body_integrator #(
        .NUM_BODIES(NUM_BODIES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // local copy of the body table
    logic signed [31:0] body_cur_x  [NUM_BODIES];
    logic signed [31:0] body_cur_y  [NUM_BODIES];
    logic signed [31:0] body_prev_x [NUM_BODIES];
    logic signed [31:0] body_prev_y [NUM_BODIES];
    logic signed [31:0] body_acc_x  [NUM_BODIES];
    logic signed [31:0] body_acc_y  [NUM_BODIES];
    logic               body_live   [NUM_BODIES];

    // step reports still owed by the dut, oldest first
    t_result slot_reports_due[$];
    int      error_count = 0;

    // one row of the directed table; the typed fields pin one slot of a step's reports
    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [15:0] dt;
        logic        typed;
        logic [4:0]  slot;
        logic        active;
        logic [31:0] ex;
        logic [31:0] ey;
    } t_plan_row;

    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        // nothing is live after reset
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1, 5'd0,  1'b0,
          32'h0000_0000, 32'h0000_0000},
        // largest acceleration at largest dt drives both axes into their clamps
        '{OP_SET_POS, 5'd0,  32'h7FFF_0000, 32'h8001_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_SET_ACC, 5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1, 5'd0,  1'b1,
          32'h7FFF_FFFF, 32'h8000_0000},
        // last slot, zero dt, carries the end marker
        '{OP_SET_POS, 5'd31, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 5'd31, 1'b1,
          32'h0000_0001, 32'hFFFF_FFFF},
        // acceleration on a slot that has no body yet; step fields other than dt ignored
        '{OP_SET_ACC, 5'd5,  32'h0001_0000, 32'hFFFF_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234, 1'b1, 5'd5,  1'b0,
          32'h0000_0000, 32'h0000_0000},
        // the kept acceleration applies once the body exists: a * 0.25
        '{OP_SET_POS, 5'd5,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1, 5'd5,  1'b1,
          32'h0000_4000, 32'hFFFF_C000},
        // exact halves: +0.5 lsb rounds up, -0.5 lsb rounds up to zero
        '{OP_SET_POS, 5'd5,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_SET_ACC, 5'd5,  32'h0000_0002, 32'hFFFF_FFFE, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1, 5'd5,  1'b1,
          32'h0000_0001, 32'h0000_0000},
        // unused operation code must not create a body
        '{OP_NONE,    5'd7,  32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 5'd7,  1'b0,
          32'h0000_0000, 32'h0000_0000},
        // set position keeps an earlier acceleration; the second step uses velocity only
        '{OP_SET_ACC, 5'd9,  32'h0004_0000, 32'h0000_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_SET_POS, 5'd9,  32'h0001_0000, 32'h0001_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1, 5'd9,  1'b1,
          32'h0002_0000, 32'h0001_0000},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1, 5'd9,  1'b1,
          32'h0003_0000, 32'h0001_0000},
        // positions at the limits hold still with no acceleration
        '{OP_SET_POS, 5'd2,  32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1, 5'd2,  1'b1,
          32'h8000_0000, 32'h7FFF_FFFF},
        // pushes past the limits and large carried velocities
        '{OP_SET_ACC, 5'd2,  32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_STEP,    5'd0,  32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0},
        '{OP_NONE,    5'd3,  32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0, 5'd0,  1'b0,
          32'h0, 32'h0}
    };

    // cur + (cur - prev) + round(acc * dt^2), clamped to 32 bits
    function automatic logic signed [31:0] verlet_advance(
        input logic signed [31:0] cur,
        input logic signed [31:0] prv,
        input logic signed [31:0] acc,
        input logic [15:0]        dt
    );
        logic [31:0]        dt_sq;
        logic signed [63:0] acc_wide;
        logic signed [63:0] dt_wide;
        logic signed [63:0] cur_wide;
        logic signed [63:0] prv_wide;
        logic signed [63:0] term;
        logic signed [63:0] total;
        dt_sq    = 32'(dt) * 32'(dt);
        acc_wide = acc;
        dt_wide  = {32'd0, dt_sq};
        cur_wide = cur;
        prv_wide = prv;
        // q16.48 product back to q16.16, halves toward plus infinity
        term  = (acc_wide * dt_wide + 64'sd2147483648) >>> 32;
        total = cur_wide + (cur_wide - prv_wide) + term;
        if (total > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (total < -64'sd2147483648)
            return 32'sh8000_0000;
        return total[31:0];
    endfunction

    // apply one accepted command to the local table and queue its reports
    task automatic integrate_item(input t_cmd c);
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        t_result            r;
        case (c.operation)
            OP_SET_POS: begin
                body_cur_x[c.body_slot]  = c.value_x;
                body_prev_x[c.body_slot] = c.value_x;
                body_cur_y[c.body_slot]  = c.value_y;
                body_prev_y[c.body_slot] = c.value_y;
                body_live[c.body_slot]   = 1'b1;
            end
            OP_SET_ACC: begin
                body_acc_x[c.body_slot] = c.value_x;
                body_acc_y[c.body_slot] = c.value_y;
            end
            OP_STEP: begin
                for (int i = 0; i < NUM_BODIES; i++) begin
                    nx = '0;
                    ny = '0;
                    if (body_live[i]) begin
                        nx = verlet_advance(body_cur_x[i], body_prev_x[i], body_acc_x[i],
                                            c.time_step);
                        ny = verlet_advance(body_cur_y[i], body_prev_y[i], body_acc_y[i],
                                            c.time_step);
                        body_prev_x[i] = body_cur_x[i];
                        body_prev_y[i] = body_cur_y[i];
                        body_cur_x[i]  = nx;
                        body_cur_y[i]  = ny;
                        body_acc_x[i]  = '0;
                        body_acc_y[i]  = '0;
                    end
                    r.slot_index = 5'(i);
                    r.is_active  = body_live[i];
                    r.new_x      = nx;
                    r.new_y      = ny;
                    r.end_of_run = (i == NUM_BODIES - 1);
                    slot_reports_due.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endtask

    // hold start high until the block takes the item
    task automatic send_item(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        integrate_item(c);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 10));
    endtask

    // hold off until every owed report has come back
    task automatic drain_reports();
        if (slot_reports_due.size() != 0) begin
            start <= 1'b0;
            while (slot_reports_due.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endtask

    // mix of full-range, small, limit and near-limit q16.16 values
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return ($urandom_range(0, 1) ? 32'h7FF0_0000 : 32'h8000_0000)
                               + $urandom_range(0, 32'h000F_FFFF);
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // every strobe retires the oldest owed report
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (slot_reports_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report, expected none actual %h", $time, o_result);
            end else begin
                want = slot_reports_due.pop_front();
                check_field("slot_index", 32'(want.slot_index), 32'(o_result.slot_index));
                check_field("is_active",  32'(want.is_active),  32'(o_result.is_active));
                check_field("new_x",      want.new_x,           o_result.new_x);
                check_field("new_y",      want.new_y,           o_result.new_y);
                check_field("end_of_run", 32'(want.end_of_run), 32'(o_result.end_of_run));
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_cmd    c;
        t_result pinned;
        int      issued;
        int      roll;
        for (int i = 0; i < NUM_BODIES; i++) begin
            body_cur_x[i]  = '0;
            body_cur_y[i]  = '0;
            body_prev_x[i] = '0;
            body_prev_y[i] = '0;
            body_acc_x[i]  = '0;
            body_acc_y[i]  = '0;
            body_live[i]   = 1'b0;
        end
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; typed rows pin one slot of the step's reports
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            maybe_idle(1'b1);
            c.operation  = directed_plan[n].op;
            c.body_slot  = directed_plan[n].idx;
            c.value_x    = directed_plan[n].vx;
            c.value_y    = directed_plan[n].vy;
            c.time_step  = directed_plan[n].dt;
            send_item(c);
            if (directed_plan[n].typed) begin
                pinned.slot_index = directed_plan[n].slot;
                pinned.is_active  = directed_plan[n].active;
                pinned.new_x      = directed_plan[n].ex;
                pinned.new_y      = directed_plan[n].ey;
                pinned.end_of_run = (directed_plan[n].slot == NUM_BODIES - 1);
                slot_reports_due[slot_reports_due.size() - NUM_BODIES
                                 + directed_plan[n].slot] = pinned;
            end
        end
        drain_reports();

        // random commands; unused-code items do not count toward the total
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            maybe_idle(issued < RANDOM_ITEMS - CALM_TAIL);
            roll = $urandom_range(0, 99);
            if (roll < 35)
                c.operation = OP_SET_POS;
            else if (roll < 65)
                c.operation = OP_SET_ACC;
            else if (roll < 95)
                c.operation = OP_STEP;
            else
                c.operation = OP_NONE;
            c.body_slot  = 5'($urandom_range(0, NUM_BODIES - 1));
            c.value_x    = pick_q16();
            c.value_y    = pick_q16();
            c.time_step  = pick_dt();
            send_item(c);
            if (c.operation != OP_NONE)
                issued++;
            if (issued == RANDOM_ITEMS / 2)
                drain_reports();
        end

        start <= 1'b0;
        while (slot_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
